/* rtl/touch_key_baseline_tracker_core_macros.svh */
// Assertion helpers shared by the tracker modules.
// Every property is clocked on clk_i and ignored while rst_ni is low.
`ifndef TOUCH_KEY_BASELINE_TRACKER_CORE_MACROS_SVH
`define TOUCH_KEY_BASELINE_TRACKER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TKBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TKBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tkbt_pkg.sv */
`default_nettype none

package tkbt_pkg;

  // Default channel count and fixed field widths.
  localparam int NumChannelsDefault = 6;
  localparam int KeyW   = 6;
  localparam int ChW    = 3;
  localparam int EnW    = 1 << ChW;
  localparam int RawW   = 16;
  localparam int CntW   = 8;
  localparam int CycW   = 8;
  localparam int RegW   = 8;
  localparam int CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgChannelEnable   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxHalfDelta    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgNoiseHalfDelta  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgNoiseCountLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFilterDelay     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTouchThreshold  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgReleaseThreshold = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [KeyW-1:0] RstChannelEnable   = '0;
  localparam logic [RegW-1:0] RstMaxHalfDelta    = 8'd5;
  localparam logic [RegW-1:0] RstNoiseHalfDelta  = 8'd2;
  localparam logic [RegW-1:0] RstNoiseCountLimit = 8'd10;
  localparam logic [RegW-1:0] RstFilterDelay     = 8'd5;
  localparam logic [RegW-1:0] RstTouchThreshold  = 8'd100;
  localparam logic [RegW-1:0] RstReleaseThreshold = 8'd80;

  typedef struct packed {
    logic [KeyW-1:0] channel_enable;
    logic [RegW-1:0] max_half_delta;
    logic [RegW-1:0] noise_half_delta;
    logic [RegW-1:0] noise_count_limit;
    logic [RegW-1:0] filter_delay_limit;
    logic [RegW-1:0] touch_threshold;
    logic [RegW-1:0] release_threshold;
  } cfg_t;

  // Per-item control decided at the front of the pipeline.
  typedef struct packed {
    logic            en;
    logic            cal;
    logic [CycW-1:0] cyc;
  } ctl_t;

  // One channel's entry in the state memory.
  typedef struct packed {
    logic [CntW-1:0] noise_count;
    logic [RawW-1:0] baseline;
  } entry_t;

  localparam int EntryW = CntW + RawW;

endpackage

`default_nettype wire

/* rtl/tkbt_mem.sv */
`default_nettype none

module tkbt_mem #(
  parameter int NUM_CHANNELS = tkbt_pkg::NumChannelsDefault,
  parameter int PtrW = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rd_en_i,
  input  wire logic [PtrW-1:0]     rd_addr_i,
  output tkbt_pkg::entry_t         rd_entry_o,
  input  wire logic                wr_en_i,
  input  wire logic [PtrW-1:0]     wr_addr_i,
  input  wire tkbt_pkg::entry_t    wr_entry_i
);

  logic [tkbt_pkg::EntryW-1:0] mem_q [NUM_CHANNELS];
  logic [tkbt_pkg::EntryW-1:0] rd_data_q;
  logic [NUM_CHANNELS-1:0]     vld_q;
  logic                        rd_vld_q;

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Entries never written read as zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = rd_vld_q ? tkbt_pkg::entry_t'(rd_data_q) : '0;

endmodule

`default_nettype wire

/* rtl/tkbt_seq.sv */
`default_nettype none

module tkbt_seq #(
  parameter int NUM_CHANNELS = tkbt_pkg::NumChannelsDefault,
  parameter int PtrW = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                acc_i,
  input  wire logic                load_i,
  input  wire tkbt_pkg::cfg_t      cfg_i,
  output logic [PtrW-1:0]          ptr_o,
  output tkbt_pkg::ctl_t           ctl_o
);

  `include "touch_key_baseline_tracker_core_macros.svh"

  localparam logic [PtrW-1:0] LastPtr = PtrW'(NUM_CHANNELS - 1);

  logic [PtrW-1:0]               ptr_q, ptr_d;
  logic [tkbt_pkg::CycW-1:0]     cyc_q, cyc_d, cyc_next;
  logic [tkbt_pkg::CycW-1:0]     next_cal_q, next_cal_d;
  logic [tkbt_pkg::EnW-1:0]      en_ext;
  logic [tkbt_pkg::ChW-1:0]      ch;
  logic                          last;
  logic                          cal;
  logic                          advance;

  // Channel decode and the calibrate-cycle match.
  always_comb begin
    ch       = tkbt_pkg::ChW'(ptr_q);
    en_ext   = tkbt_pkg::EnW'(cfg_i.channel_enable);
    last     = (ptr_q == LastPtr);
    cal      = (next_cal_q == cyc_q);
    advance  = acc_i && !load_i;
    cyc_next = (advance && last) ? cyc_q + 1'b1 : cyc_q;
  end

  // Pointer moves on every accepted non-load sample; cycle counter on wrap.
  always_comb begin
    ptr_d      = ptr_q;
    cyc_d      = cyc_q;
    next_cal_d = next_cal_q;
    if (advance) begin
      ptr_d = last ? '0 : ptr_q + 1'b1;
      if (last) begin
        cyc_d = cyc_next;
        if (cal) begin
          next_cal_d = cyc_q + cfg_i.filter_delay_limit;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      cyc_q      <= '0;
      next_cal_q <= '0;
    end else begin
      ptr_q      <= ptr_d;
      cyc_q      <= cyc_d;
      next_cal_q <= next_cal_d;
    end
  end

  assign ptr_o     = ptr_q;
  assign ctl_o.en  = en_ext[ch];
  assign ctl_o.cal = cal;
  assign ctl_o.cyc = cyc_next;

  `TKBT_ASSERT_NOW(a_ptr_range, 1'b1, ptr_q <= LastPtr, "channel pointer out of range")
  `TKBT_ASSERT_NEXT(a_cyc_wrap, advance && last, cyc_q == $past(cyc_q) + 1'b1,
                    "cycle counter did not advance at pointer wrap")

endmodule

`default_nettype wire

/* rtl/tkbt_upd.sv */
`default_nettype none

module tkbt_upd #(
  parameter int PtrW = 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          acc_i,
  input  wire logic [tkbt_pkg::RawW-1:0]     raw_i,
  input  wire logic                          load_i,
  input  wire logic [PtrW-1:0]               ptr_i,
  input  wire tkbt_pkg::ctl_t                ctl_i,
  input  wire tkbt_pkg::cfg_t                cfg_i,
  input  wire tkbt_pkg::entry_t              rd_entry_i,
  output logic                               in_ready_o,
  output logic                               wr_en_o,
  output logic [PtrW-1:0]                    wr_addr_o,
  output tkbt_pkg::entry_t                   wr_entry_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [tkbt_pkg::ChW-1:0]           out_channel_o,
  output logic [tkbt_pkg::KeyW-1:0]          out_pressed_o,
  output logic [tkbt_pkg::CycW-1:0]          out_cycle_o
);

  `include "touch_key_baseline_tracker_core_macros.svh"

  // Update stage registers.
  logic                          s1_valid_q;
  logic [PtrW-1:0]               s1_ptr_q;
  logic [tkbt_pkg::RawW-1:0]     s1_raw_q;
  logic                          s1_load_q;
  tkbt_pkg::ctl_t                s1_ctl_q;
  logic                          fwd_q, fwd_d;
  tkbt_pkg::entry_t              fwd_entry_q;

  logic [tkbt_pkg::KeyW-1:0]     side_q, side_d;
  logic [tkbt_pkg::KeyW-1:0]     pressed_q, pressed_d;

  logic                          out_valid_q;
  logic [tkbt_pkg::ChW-1:0]      out_channel_q;
  logic [tkbt_pkg::KeyW-1:0]     out_pressed_q;
  logic [tkbt_pkg::CycW-1:0]     out_cycle_q;

  logic                          s1_adv;
  logic                          fire;
  tkbt_pkg::entry_t              cur;
  tkbt_pkg::entry_t              cal_entry;
  logic [tkbt_pkg::EnW-1:0]      onehot;
  logic [tkbt_pkg::KeyW-1:0]     keybit;
  logic                          side_bit;
  logic                          prs_bit;
  logic [tkbt_pkg::RawW-1:0]     d16;
  logic signed [tkbt_pkg::RawW:0] diff;
  logic signed [tkbt_pkg::RawW:0] lim;
  logic signed [tkbt_pkg::RawW:0] neg_rel;
  logic signed [tkbt_pkg::RawW:0] neg_touch;
  logic                          near;
  logic                          positive;
  logic                          same;
  logic [tkbt_pkg::CntW-1:0]     cnt;
  logic                          side_new;
  logic                          prs_new;

  // Stage handshake: the output register frees the update stage.
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign fire       = s1_valid_q && s1_adv;

  // A write in flight to the entry now being read is forwarded next cycle.
  assign fwd_d = s1_valid_q && wr_en_o && (s1_ptr_q == ptr_i);

  // Difference, side and count arithmetic for the channel in this stage.
  always_comb begin
    cur       = fwd_q ? fwd_entry_q : rd_entry_i;
    onehot    = tkbt_pkg::EnW'(1) << s1_ptr_q;
    keybit    = onehot[tkbt_pkg::KeyW-1:0];
    side_bit  = |(side_q & keybit);
    prs_bit   = |(pressed_q & keybit);
    d16       = s1_raw_q - cur.baseline;
    diff      = $signed({d16[tkbt_pkg::RawW-1], d16});
    lim       = $signed({{(tkbt_pkg::RawW + 1 - tkbt_pkg::RegW){1'b0}}, cfg_i.max_half_delta});
    neg_rel   = -$signed({{(tkbt_pkg::RawW + 1 - tkbt_pkg::RegW){1'b0}},
                          cfg_i.release_threshold});
    neg_touch = -$signed({{(tkbt_pkg::RawW + 1 - tkbt_pkg::RegW){1'b0}},
                          cfg_i.touch_threshold});
    near      = (diff < lim) && (diff > -lim);
    positive  = !d16[tkbt_pkg::RawW-1] && (|d16);
    same      = positive ? side_bit : !side_bit;
    cnt       = cur.noise_count + 1'b1;
  end

  // Calibration: small differences track the sample, persistent drift steps.
  always_comb begin
    cal_entry = cur;
    side_new  = side_bit;
    if (near) begin
      cal_entry.baseline = s1_raw_q;
    end else if (same) begin
      cal_entry.noise_count = cnt;
      if (cnt >= cfg_i.noise_count_limit) begin
        cal_entry.noise_count = '0;
        if (positive) begin
          cal_entry.baseline = cur.baseline + tkbt_pkg::RawW'(cfg_i.noise_half_delta);
        end else begin
          cal_entry.baseline = cur.baseline - tkbt_pkg::RawW'(cfg_i.noise_half_delta);
        end
      end
    end else begin
      side_new              = positive;
      cal_entry.noise_count = tkbt_pkg::CntW'(1);
    end
  end

  // Press hysteresis on the difference taken before calibration.
  assign prs_new = prs_bit ? !(diff > neg_rel) : (diff < neg_touch);

  // Write-back and mask updates.
  always_comb begin
    wr_en_o    = 1'b0;
    wr_addr_o  = s1_ptr_q;
    wr_entry_o = cal_entry;
    side_d     = side_q;
    pressed_d  = pressed_q;
    if (fire) begin
      if (s1_load_q) begin
        wr_en_o             = 1'b1;
        wr_entry_o          = cur;
        wr_entry_o.baseline = s1_raw_q;
      end else if (s1_ctl_q.en) begin
        if (s1_ctl_q.cal) begin
          wr_en_o = 1'b1;
          side_d  = side_new ? (side_q | keybit) : (side_q & ~keybit);
        end
        pressed_d = prs_new ? (pressed_q | keybit) : (pressed_q & ~keybit);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      side_q      <= '0;
      pressed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= acc_i;
      end
      if (acc_i) begin
        fwd_q <= fwd_d;
      end
      side_q    <= side_d;
      pressed_q <= pressed_d;
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_ptr_q  <= ptr_i;
      s1_raw_q  <= raw_i;
      s1_load_q <= load_i;
      s1_ctl_q  <= ctl_i;
    end
    if (wr_en_o) begin
      fwd_entry_q <= wr_entry_o;
    end
    if (fire) begin
      out_channel_q <= tkbt_pkg::ChW'(s1_ptr_q);
      out_pressed_q <= pressed_d;
      out_cycle_q   <= s1_ctl_q.cyc;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign out_pressed_o = out_pressed_q;
  assign out_cycle_o   = out_cycle_q;

  `TKBT_ASSERT_NOW(a_wr_on_fire, wr_en_o, fire, "entry write without an advancing item")
  `TKBT_ASSERT_NEXT(a_one_key, 1'b1, $countones(pressed_q ^ $past(pressed_q)) <= 1,
                    "more than one key changed in one cycle")

endmodule

`default_nettype wire

/* rtl/touch_key_baseline_tracker_core.sv */
// Capacitive key baseline tracker.
// Input stream: one raw sample per transfer on s_axis_tdata, for the channel
// under an internal round-robin pointer; s_axis_tuser set stores the sample
// as that channel's baseline without advancing the pointer.
// Output stream: one result per accepted sample on m_axis_tdata with the
// channel index, the pressed-key mask after the sample and the count of
// completed full channel passes.
// A transfer passes the update stage and output registers to m_axis_tvalid.
// Samples are taken every cycle unless stalled: the per-channel baseline
// and noise count sit in a small memory with a registered read, and a write
// to the entry read in the same cycle is forwarded into the update stage.
// When m_axis_tready is low the output register holds its result; once the
// update stage also holds a sample, s_axis_tready follows m_axis_tready in
// the same cycle, so nothing is lost. Reset clears all keys, counters and
// the pointer, loads the register defaults, and makes every channel's
// baseline and noise count read as zero. The user writes the configuration
// port only while the streams are idle; the block does not enforce it.
`default_nettype none

module touch_key_baseline_tracker_core #(
  parameter int NUM_CHANNELS = tkbt_pkg::NumChannelsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // raw_sample [15:0]
  input  wire logic [15:0]                    s_axis_tdata,
  // load_baseline [0]
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // channel [2:0], pressed_keys [8:3], cycle_count [16:9], zero fill [23:17]
  output logic [23:0]                         m_axis_tdata,
  input  wire logic                           cfg_we_i,
  input  wire logic [tkbt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [tkbt_pkg::RegW-1:0]      cfg_data_i
);

  localparam int PtrW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int OutW = tkbt_pkg::ChW + tkbt_pkg::KeyW + tkbt_pkg::CycW;

  tkbt_pkg::cfg_t                 cfg_q, cfg_d;
  tkbt_pkg::ctl_t                 ctl;
  tkbt_pkg::entry_t               rd_entry;
  tkbt_pkg::entry_t               wr_entry;
  logic [PtrW-1:0]                ptr;
  logic [PtrW-1:0]                wr_addr;
  logic                           wr_en;
  logic                           acc;
  logic [tkbt_pkg::ChW-1:0]       out_channel;
  logic [tkbt_pkg::KeyW-1:0]      out_pressed;
  logic [tkbt_pkg::CycW-1:0]      out_cycle;

  assign acc = s_axis_tvalid && s_axis_tready;

  // Configuration register file.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tkbt_pkg::CfgChannelEnable:
          cfg_d.channel_enable = cfg_data_i[tkbt_pkg::KeyW-1:0];
        tkbt_pkg::CfgMaxHalfDelta:     cfg_d.max_half_delta     = cfg_data_i;
        tkbt_pkg::CfgNoiseHalfDelta:   cfg_d.noise_half_delta   = cfg_data_i;
        tkbt_pkg::CfgNoiseCountLimit:  cfg_d.noise_count_limit  = cfg_data_i;
        tkbt_pkg::CfgFilterDelay:      cfg_d.filter_delay_limit = cfg_data_i;
        tkbt_pkg::CfgTouchThreshold:   cfg_d.touch_threshold    = cfg_data_i;
        tkbt_pkg::CfgReleaseThreshold: cfg_d.release_threshold  = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_enable     <= tkbt_pkg::RstChannelEnable;
      cfg_q.max_half_delta     <= tkbt_pkg::RstMaxHalfDelta;
      cfg_q.noise_half_delta   <= tkbt_pkg::RstNoiseHalfDelta;
      cfg_q.noise_count_limit  <= tkbt_pkg::RstNoiseCountLimit;
      cfg_q.filter_delay_limit <= tkbt_pkg::RstFilterDelay;
      cfg_q.touch_threshold    <= tkbt_pkg::RstTouchThreshold;
      cfg_q.release_threshold  <= tkbt_pkg::RstReleaseThreshold;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tkbt_seq #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .PtrW         (PtrW)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .load_i (s_axis_tuser),
    .cfg_i  (cfg_q),
    .ptr_o  (ptr),
    .ctl_o  (ctl)
  );

  tkbt_mem #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .PtrW         (PtrW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (acc),
    .rd_addr_i  (ptr),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry)
  );

  tkbt_upd #(
    .PtrW (PtrW)
  ) u_upd (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .raw_i         (s_axis_tdata),
    .load_i        (s_axis_tuser),
    .ptr_i         (ptr),
    .ctl_i         (ctl),
    .cfg_i         (cfg_q),
    .rd_entry_i    (rd_entry),
    .in_ready_o    (s_axis_tready),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_entry_o    (wr_entry),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_channel_o (out_channel),
    .out_pressed_o (out_pressed),
    .out_cycle_o   (out_cycle)
  );

  assign m_axis_tdata = {{(24 - OutW){1'b0}}, out_cycle, out_pressed, out_channel};

endmodule

`default_nettype wire
